// File: sv/scsi_block_command_decoder_macros.svh
// Assertion macros for the SCSI block command decoder
`ifndef SCSI_BLOCK_COMMAND_DECODER_MACROS_SVH
`define SCSI_BLOCK_COMMAND_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SCB_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define SCB_ASSERT(lbl, prop, msg)
`define SCB_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: sv/scb_pkg.sv
// Shared types and constants of the SCSI block command decoder
`timescale 1ns / 1ps
`default_nettype none
package scb_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned MLEN_W      = 7;
  localparam int unsigned NWORDS_W    = 4;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;
  localparam int unsigned DIV_STEPS   = 32;
  localparam int unsigned DIV_CNT_W   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY    = 3'd0,
    CFG_BLOCK_BYTES = 3'd1,
    CFG_VENDOR      = 3'd2,
    CFG_PRODUCT     = 3'd3,
    CFG_REVISION    = 3'd4,
    CFG_SERIAL      = 3'd5
  } cfg_idx_e;

  localparam logic [7:0] OPC_TUR         = 8'h00;
  localparam logic [7:0] OPC_MODE_SENSE6 = 8'h1a;
  localparam logic [7:0] OPC_INQUIRY     = 8'h12;
  localparam logic [7:0] OPC_RCAP10      = 8'h25;
  localparam logic [7:0] OPC_SAI16       = 8'h9e;
  localparam logic [7:0] OPC_WRITE10     = 8'h2a;
  localparam logic [7:0] OPC_WRITE16     = 8'h8a;
  localparam logic [7:0] OPC_READ16      = 8'h88;
  localparam logic [7:0] OPC_READ10      = 8'h28;
  localparam logic [7:0] OPC_READ6       = 8'h08;
  localparam logic [7:0] OPC_REPORT_LUNS = 8'ha0;

  localparam logic [7:0] PAGE_STD        = 8'h00;
  localparam logic [7:0] PAGE_DEV_ID     = 8'h83;
  localparam logic [7:0] PAGE_BLK_LIMITS = 8'hb0;
  localparam logic [7:0] PAGE_BLK_CHAR   = 8'hb1;
  localparam logic [4:0] SA_RCAP16       = 5'h10;
  localparam logic [4:0] SA_LBA_STATUS   = 5'h12;

  localparam logic [1:0] STATUS_ASIS = 2'd0;
  localparam logic [1:0] STATUS_GOOD = 2'd1;
  localparam logic [1:0] STATUS_R2T  = 2'd2;
  localparam logic [1:0] SENSE_NONE       = 2'd0;
  localparam logic [1:0] SENSE_FIXED_OPC  = 2'd1;
  localparam logic [1:0] SENSE_DESC_FIELD = 2'd2;
  localparam logic [1:0] SOP_NONE  = 2'd0;
  localparam logic [1:0] SOP_READ  = 2'd1;
  localparam logic [1:0] SOP_WRITE = 2'd2;

  typedef enum logic [3:0] {
    K_TUR, K_MSENSE, K_INQ_STD, K_INQ_DEVID, K_INQ_BLIM, K_INQ_BCHAR, K_INQ_BAD,
    K_RCAP10, K_RCAP16, K_LBA_STATUS, K_SA_NONE, K_READ, K_WRITE, K_RLUNS, K_UNKNOWN
  } kind_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_MUL_T = 8'b0000_0100,
    S_CHK_T = 8'b0000_1000,
    S_MUL_O = 8'b0001_0000,
    S_MUL_R = 8'b0010_0000,
    S_HDR   = 8'b0100_0000,
    S_WORD  = 8'b1000_0000
  } state_e;

  typedef struct packed {
    kind_e                 kind;
    logic [63:0]           lba;
    logic [31:0]           tl;
    logic [MLEN_W-1:0]     mlen;
    logic [NWORDS_W-1:0]   nwords;
    logic                  has_data;
    logic [31:0]           rx;
    logic [63:0]           cdb_head;
    logic [63:0]           cdb_tail;
  } rec_t;

  typedef struct packed {
    logic [63:0] capacity;
    logic [31:0] block_bytes;
    logic [63:0] vendor;
    logic [63:0] product;
    logic [31:0] revision;
    logic [63:0] serial;
  } cfg_t;

  typedef struct packed {
    logic        is_header;
    logic [1:0]  status;
    logic [1:0]  sense;
    logic        meta;
    logic [63:0] len;
    logic [1:0]  op;
    logic [63:0] lba;
    logic [31:0] count;
    logic [63:0] off;
    logic [63:0] rem;
    logic [63:0] word;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// File: sv/scb_front.sv
// Front end: accepts command blocks and classifies them
`timescale 1ns / 1ps
`default_nettype none
module scb_front import scb_pkg::*; (
  input  wire logic        push_i,
  input  wire logic        full_i,
  input  wire logic [63:0] cdb_head_i,
  input  wire logic [63:0] cdb_tail_i,
  input  wire logic        has_data_i,
  input  wire logic [31:0] data_size_i,
  output logic             wr_o,
  output rec_t             rec_o
);

  logic [7:0]        opc, c1, c2;
  logic [15:0]       alloc;
  logic [MLEN_W-1:0] plen;
  logic [7:0]        nw_sum;

  assign opc   = cdb_head_i[63:56];
  assign c1    = cdb_head_i[55:48];
  assign c2    = cdb_head_i[47:40];
  assign alloc = cdb_head_i[39:24];
  assign wr_o  = push_i & ~full_i;

  always_comb begin
    rec_o          = '0;
    rec_o.cdb_head = cdb_head_i;
    rec_o.cdb_tail = cdb_tail_i;
    rec_o.has_data = has_data_i;
    rec_o.rx       = data_size_i;
    rec_o.kind     = K_UNKNOWN;
    plen           = '0;
    case (opc)
      OPC_TUR: begin
        rec_o.kind = K_TUR;
      end
      OPC_MODE_SENSE6: begin
        rec_o.kind = K_MSENSE;
        plen       = 7'd4;
      end
      OPC_INQUIRY: begin
        rec_o.kind = K_INQ_BAD;
        if (!c1[0]) begin
          if (c2 == PAGE_STD) begin
            rec_o.kind = K_INQ_STD;
            plen       = 7'd68;
          end
        end else if (c2 == PAGE_DEV_ID) begin
          rec_o.kind = K_INQ_DEVID;
          plen       = 7'd9;
        end else if (c2 == PAGE_BLK_LIMITS) begin
          rec_o.kind = K_INQ_BLIM;
          plen       = 7'd64;
        end else if (c2 == PAGE_BLK_CHAR) begin
          rec_o.kind = K_INQ_BCHAR;
          plen       = 7'd64;
        end
        if ({9'b0, plen} > alloc) begin
          plen = alloc[MLEN_W-1:0];
        end
      end
      OPC_RCAP10: begin
        rec_o.kind = K_RCAP10;
        plen       = 7'd8;
      end
      OPC_SAI16: begin
        rec_o.kind = K_SA_NONE;
        if (c1[4:0] == SA_RCAP16) begin
          rec_o.kind = K_RCAP16;
          plen       = 7'd32;
        end else if (c1[4:0] == SA_LBA_STATUS) begin
          rec_o.kind = K_LBA_STATUS;
          plen       = 7'd24;
        end
      end
      OPC_WRITE10, OPC_READ10: begin
        rec_o.kind = (opc == OPC_WRITE10) ? K_WRITE : K_READ;
        rec_o.lba  = {32'b0, cdb_head_i[47:16]};
        rec_o.tl   = {16'b0, cdb_head_i[7:0], cdb_tail_i[63:56]};
      end
      OPC_WRITE16, OPC_READ16: begin
        rec_o.kind = (opc == OPC_WRITE16) ? K_WRITE : K_READ;
        rec_o.lba  = {cdb_head_i[47:0], cdb_tail_i[63:48]};
        rec_o.tl   = cdb_tail_i[47:16];
      end
      OPC_READ6: begin
        rec_o.kind = K_READ;
        rec_o.lba  = {43'b0, cdb_head_i[52:32]};
        rec_o.tl   = (cdb_head_i[31:24] == 8'd0) ? 32'd256 : {24'b0, cdb_head_i[31:24]};
      end
      OPC_REPORT_LUNS: begin
        rec_o.kind = K_RLUNS;
        plen       = 7'd16;
      end
      default: begin
        rec_o.kind = K_UNKNOWN;
      end
    endcase
    rec_o.mlen   = plen;
    nw_sum       = ({1'b0, plen} + 8'd7) >> 3;
    rec_o.nwords = nw_sum[NWORDS_W-1:0];
  end

endmodule
`default_nettype wire

// File: sv/scb_queue.sv
// Short queue of classified commands between front and back
`timescale 1ns / 1ps
`default_nettype none
module scb_queue import scb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  rec_t      rec_i,
  input  wire logic rd_i,
  output rec_t      rec_o,
  output logic      full_o,
  output logic      empty_o
);

  rec_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= wptr_q + 1'b1;
      if (rd_i) rptr_q <= rptr_q + 1'b1;
      if (wr_i && !rd_i) cnt_q <= cnt_q + 1'b1;
      else if (rd_i && !wr_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= rec_i;
  end

endmodule
`default_nettype wire

// File: sv/scb_back.sv
// Back end: size arithmetic, header and metadata word emission
`timescale 1ns / 1ps
`default_nettype none
`include "scsi_block_command_decoder_macros.svh"
module scb_back import scb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  rec_t      rec_i,
  input  wire logic qempty_i,
  output logic      qrd_o,
  input  wire logic pop_i,
  output logic      ovalid_o,
  output res_t      res_o
);

  state_e               state_q, state_d;
  rec_t                 rec_q, rec_d;
  logic [1:0]           status_q, status_d, sense_q, sense_d, op_q, op_d;
  logic                 meta_q, meta_d;
  logic [63:0]          len_q, len_d, lba_q, lba_d, off_q, off_d, rem_q, rem_d;
  logic [63:0]          prod_q, prod_d;
  logic [31:0]          cnt_q, cnt_d, mul_a_q, mul_a_d, quot_q, quot_d, rmd_q, rmd_d;
  logic [DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  logic [NWORDS_W-1:0]  words_q, words_d, k_q, k_d;
  logic                 ovalid_q;
  res_t                 res_q, emit_res;
  logic                 emit, out_free;
  logic [63:0]          mul_prod;
  logic [32:0]          dtrial, ddiff;
  logic                 dge;
  logic [63:0]          raw_word, word;
  logic [MLEN_W-1:0]    rem_bytes;

  assign out_free = ~ovalid_q | pop_i;
  assign mul_prod = mul_a_q * cfg_i.block_bytes;
  assign dtrial   = {rmd_q, quot_q[31]};
  assign ddiff    = dtrial - {1'b0, cfg_i.block_bytes};
  assign dge      = (dtrial >= {1'b0, cfg_i.block_bytes});
  assign ovalid_o = ovalid_q;
  assign res_o    = res_q;

  always_comb begin
    raw_word = '0;
    case (rec_q.kind)
      K_MSENSE:    if (k_q == 4'd0) raw_word = 64'h0300_0000_0000_0000;
      K_INQ_DEVID: begin
        if (k_q == 4'd0) raw_word = 64'h0083_0001_0000_0001;
        else if (k_q == 4'd1) raw_word = 64'h0100_0000_0000_0000;
      end
      K_INQ_BLIM:  if (k_q == 4'd0) raw_word = 64'h00b0_003c_0000_0000;
      K_INQ_BCHAR: if (k_q == 4'd0) raw_word = 64'h00b1_003c_1c20_0000;
      K_INQ_STD: begin
        case (k_q)
          4'd0:    raw_word = 64'h0000_0502_3f00_0000;
          4'd1:    raw_word = cfg_i.vendor;
          4'd2:    raw_word = cfg_i.product;
          4'd4:    raw_word = {cfg_i.revision, cfg_i.serial[63:32]};
          4'd5:    raw_word = {cfg_i.serial[31:0], 32'h0};
          4'd7:    raw_word = 64'h0000_04c0_0960_01fb;
          4'd8:    raw_word = 64'h0120_0000_0000_0000;
          default: raw_word = '0;
        endcase
      end
      K_RCAP10: begin
        if (k_q == 4'd0) begin
          raw_word = {(cfg_i.capacity > 64'hffff_ffff) ? 32'hffff_ffff
                                                       : cfg_i.capacity[31:0],
                      cfg_i.block_bytes};
        end
      end
      K_RCAP16: begin
        if (k_q == 4'd0) raw_word = cfg_i.capacity;
        else if (k_q == 4'd1) raw_word = {cfg_i.block_bytes, 8'h10, 24'h0};
      end
      K_LBA_STATUS: begin
        if (k_q == 4'd0) raw_word = 64'h0000_0015_0000_0000;
        else if (k_q == 4'd1) raw_word = {rec_q.cdb_head[47:0], rec_q.cdb_tail[63:48]};
        else if (k_q == 4'd2) raw_word = {rec_q.cdb_tail[47:16], 32'h0};
      end
      K_RLUNS:     if (k_q == 4'd0) raw_word = 64'h0000_0001_0000_0000;
      default:     raw_word = '0;
    endcase
  end

  // keep only bytes that lie below the payload length
  assign rem_bytes = len_q[MLEN_W-1:0] - {k_q, 3'b000};
  always_comb begin
    word = '0;
    for (int i = 0; i < 8; i++) begin
      if (MLEN_W'(i) < rem_bytes) word[63-8*i -: 8] = raw_word[63-8*i -: 8];
    end
  end

  always_comb begin
    state_d  = state_q;
    rec_d    = rec_q;
    status_d = status_q;
    sense_d  = sense_q;
    op_d     = op_q;
    meta_d   = meta_q;
    len_d    = len_q;
    lba_d    = lba_q;
    off_d    = off_q;
    rem_d    = rem_q;
    prod_d   = prod_q;
    cnt_d    = cnt_q;
    mul_a_d  = mul_a_q;
    quot_d   = quot_q;
    rmd_d    = rmd_q;
    dcnt_d   = dcnt_q;
    words_d  = words_q;
    k_d      = k_q;
    qrd_o    = 1'b0;
    emit     = 1'b0;
    emit_res = '0;
    case (state_q)
      S_IDLE: begin
        if (!qempty_i) begin
          qrd_o    = 1'b1;
          rec_d    = rec_i;
          status_d = STATUS_ASIS;
          sense_d  = SENSE_NONE;
          op_d     = SOP_NONE;
          meta_d   = 1'b1;
          len_d    = {{(64-MLEN_W){1'b0}}, rec_i.mlen};
          lba_d    = '0;
          off_d    = '0;
          rem_d    = '0;
          cnt_d    = '0;
          words_d  = rec_i.nwords;
          k_d      = '0;
          mul_a_d  = rec_i.tl;
          quot_d   = rec_i.rx;
          rmd_d    = '0;
          dcnt_d   = '0;
          state_d  = S_HDR;
          case (rec_i.kind)
            K_TUR:     status_d = STATUS_GOOD;
            K_INQ_BAD: sense_d  = SENSE_DESC_FIELD;
            K_UNKNOWN: sense_d  = SENSE_FIXED_OPC;
            K_READ: begin
              meta_d  = 1'b0;
              state_d = S_MUL_T;
            end
            K_WRITE: begin
              if (!rec_i.has_data) status_d = STATUS_R2T;
              else if (cfg_i.block_bytes != '0) state_d = S_DIV;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        rmd_d  = dge ? ddiff[31:0] : dtrial[31:0];
        quot_d = {quot_q[30:0], dge};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = S_MUL_T;
      end
      S_MUL_T: begin
        prod_d  = mul_prod;
        state_d = S_CHK_T;
      end
      S_CHK_T: begin
        state_d = S_HDR;
        if (rec_q.kind == K_READ) begin
          len_d = prod_q;
          if (prod_q != '0) begin
            op_d  = SOP_READ;
            cnt_d = rec_q.tl;
            lba_d = rec_q.lba;
          end
        end else if (quot_q != '0) begin
          op_d  = SOP_WRITE;
          cnt_d = rec_q.tl;
          lba_d = rec_q.lba;
          if (prod_q == {32'b0, rec_q.rx}) begin
            status_d = STATUS_GOOD;
          end else begin
            status_d = STATUS_R2T;
            mul_a_d  = quot_q;
            state_d  = S_MUL_O;
          end
        end
      end
      S_MUL_O: begin
        off_d   = mul_prod;
        mul_a_d = rec_q.tl - quot_q;
        state_d = S_MUL_R;
      end
      S_MUL_R: begin
        rem_d   = (rec_q.tl > quot_q) ? mul_prod : '0;
        state_d = S_HDR;
      end
      S_HDR: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_res.is_header = 1'b1;
          emit_res.status    = status_q;
          emit_res.sense     = sense_q;
          emit_res.meta      = meta_q;
          emit_res.len       = len_q;
          emit_res.op        = op_q;
          emit_res.lba       = lba_q;
          emit_res.count     = cnt_q;
          emit_res.off       = off_q;
          emit_res.rem       = rem_q;
          emit_res.last      = (words_q == '0);
          state_d            = (words_q == '0) ? S_IDLE : S_WORD;
        end
      end
      S_WORD: begin
        if (out_free) begin
          emit          = 1'b1;
          emit_res.word = word;
          emit_res.last = (k_q == words_q - 1'b1);
          k_d           = k_q + 1'b1;
          if (k_q == words_q - 1'b1) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      dcnt_q   <= '0;
      k_q      <= '0;
      words_q  <= '0;
    end else begin
      state_q <= state_d;
      dcnt_q  <= dcnt_d;
      k_q     <= k_d;
      words_q <= words_d;
      if (emit) ovalid_q <= 1'b1;
      else if (pop_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q    <= rec_d;
    status_q <= status_d;
    sense_q  <= sense_d;
    op_q     <= op_d;
    meta_q   <= meta_d;
    len_q    <= len_d;
    lba_q    <= lba_d;
    off_q    <= off_d;
    rem_q    <= rem_d;
    prod_q   <= prod_d;
    cnt_q    <= cnt_d;
    mul_a_q  <= mul_a_d;
    quot_q   <= quot_d;
    rmd_q    <= rmd_d;
    if (emit) res_q <= emit_res;
  end

  `SCB_ASSERT(a_word_index_range, (state_q == S_WORD) |-> (k_q < words_q), "word index past count")
  `SCB_ASSERT(a_div_rem_bound, (state_q == S_DIV) |-> (rmd_q < cfg_i.block_bytes), "divider remainder too big")
  `SCB_ASSERT(a_words_only_meta, (state_q == S_WORD) |-> meta_q, "payload words on read data")
  `SCB_ASSERT_NEVER(a_no_read_empty, qrd_o && qempty_i, "queue read while empty")

endmodule
`default_nettype wire

// File: sv/scsi_block_command_decoder.sv
// Top level of the SCSI block command decoder
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  command  | push / full      | cdb_head_i cdb_tail_i has_data_i data_size_i
//  result   | empty / pop      | is_header_o .. payload_word_o last_o
//  config   | cfg_we_i         | cfg_idx_i cfg_data_i
//
// Metadata commands emit a header, then their words; reads multiply first.
// Writes with data run the 32-step block-size divider if block_bytes != 0.
// A two-entry command queue decouples intake from the back end.
// Reset clears control state and loads block_bytes with 512.
// The back end stalls only when the result register is full and not popped.
`timescale 1ns / 1ps
`default_nettype none
module scsi_block_command_decoder import scb_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [63:0]          cdb_head_i,
  input  wire logic [63:0]          cdb_tail_i,
  input  wire logic                 has_data_i,
  input  wire logic [31:0]          data_size_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic                      is_header_o,
  output logic [1:0]                status_kind_o,
  output logic [1:0]                sense_kind_o,
  output logic                      payload_is_meta_o,
  output logic [63:0]               payload_length_o,
  output logic [1:0]                storage_op_o,
  output logic [63:0]               start_lba_o,
  output logic [31:0]               block_count_o,
  output logic [63:0]               r2t_offset_o,
  output logic [63:0]               r2t_remaining_o,
  output logic [63:0]               payload_word_o,
  output logic                      last_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [63:0]          cfg_data_i
);

  cfg_t cfg_q;
  rec_t front_rec, queue_rec;
  logic front_wr, q_full, q_empty, q_rd, ovalid;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{block_bytes: 32'd512, default: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CAPACITY:    cfg_q.capacity    <= cfg_data_i;
        CFG_BLOCK_BYTES: cfg_q.block_bytes <= cfg_data_i[31:0];
        CFG_VENDOR:      cfg_q.vendor      <= cfg_data_i;
        CFG_PRODUCT:     cfg_q.product     <= cfg_data_i;
        CFG_REVISION:    cfg_q.revision    <= cfg_data_i[31:0];
        CFG_SERIAL:      cfg_q.serial      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  scb_front u_front (
    .push_i      (push),
    .full_i      (q_full),
    .cdb_head_i  (cdb_head_i),
    .cdb_tail_i  (cdb_tail_i),
    .has_data_i  (has_data_i),
    .data_size_i (data_size_i),
    .wr_o        (front_wr),
    .rec_o       (front_rec)
  );

  scb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (front_wr),
    .rec_i   (front_rec),
    .rd_i    (q_rd),
    .rec_o   (queue_rec),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  scb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .rec_i    (queue_rec),
    .qempty_i (q_empty),
    .qrd_o    (q_rd),
    .pop_i    (pop),
    .ovalid_o (ovalid),
    .res_o    (res)
  );

  assign full              = q_full;
  assign empty             = ~ovalid;
  assign is_header_o       = res.is_header;
  assign status_kind_o     = res.status;
  assign sense_kind_o      = res.sense;
  assign payload_is_meta_o = res.meta;
  assign payload_length_o  = res.len;
  assign storage_op_o      = res.op;
  assign start_lba_o       = res.lba;
  assign block_count_o     = res.count;
  assign r2t_offset_o      = res.off;
  assign r2t_remaining_o   = res.rem;
  assign payload_word_o    = res.word;
  assign last_o            = res.last;

endmodule
`default_nettype wire
